// File: rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants of the rational arithmetic unit
// Field widths, operation and status codes, and controller-datapath interface.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int WORD_BITS   = 32;
    localparam int NUM_BITS    = 32;
    localparam int DEN_BITS    = 31;
    localparam int OP_BITS     = 2;
    localparam int STATUS_BITS = 2;

    // Operation codes
    localparam logic [OP_BITS-1:0] OP_ADD = 2'd0;
    localparam logic [OP_BITS-1:0] OP_SUB = 2'd1;
    localparam logic [OP_BITS-1:0] OP_MUL = 2'd2;
    localparam logic [OP_BITS-1:0] OP_DIV = 2'd3;

    // Status codes
    localparam logic [STATUS_BITS-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_DZ   = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_OVFL = 2'd2;

    // Datapath commands
    typedef enum logic [3:0] {
        DP_NONE,
        DP_LOAD,
        DP_MUL0,
        DP_MUL1,
        DP_MUL2,
        DP_MAG,
        DP_GCD_STEP,
        DP_DIVN_INIT,
        DP_DIVD_INIT,
        DP_DIV_STEP,
        DP_OUT,
        DP_OUT_DZ
    } t_dp_cmd;

    // Datapath status toward the controller
    typedef struct packed {
        logic dz;
        logic gcd_done;
        logic div_done;
    } t_dp_sts;

endpackage

// File: rtl/rau_datapath.sv
// ----------------------------------------------------------------------------
// rau_datapath: operand registers, shared multiplier, binary gcd, divider
// Executes one command per cycle and holds the result register.
// ----------------------------------------------------------------------------
module rau_datapath import rau_pkg::*; #(
    parameter int W = WORD_BITS
) (
    input  logic                          i_clk,
    input  t_dp_cmd                       i_cmd,
    output t_dp_sts                       o_sts,
    input  logic [OP_BITS-1:0]            i_op,
    input  logic signed [NUM_BITS-1:0]    i_a_num,
    input  logic [DEN_BITS-1:0]           i_a_den,
    input  logic signed [NUM_BITS-1:0]    i_b_num,
    input  logic [DEN_BITS-1:0]           i_b_den,
    output logic signed [NUM_BITS-1:0]    o_res_num,
    output logic [DEN_BITS-1:0]           o_res_den,
    output logic [STATUS_BITS-1:0]        o_status
);

    localparam int DW = 2 * W;
    localparam int NW = 2 * W + 1;
    localparam int CW = $clog2(DW + 1);
    localparam logic [DW-1:0] HALF = DW'(1) << (W - 1);

    // Operands
    logic [OP_BITS-1:0]    r_op;
    logic signed [W-1:0]   r_an, r_bn;
    logic [W-2:0]          r_ad, r_bd;

    // Products and magnitudes
    logic signed [DW-1:0]  r_prod;
    logic signed [NW-1:0]  r_num;
    logic [DW-1:0]         r_nmag, r_dmag;
    logic                  r_neg;

    // Gcd and divider state
    logic [DW-1:0]         r_u, r_v;
    logic [CW-1:0]         r_k;
    logic [DW-1:0]         r_rem, r_quo, r_nq;
    logic [CW-1:0]         r_cnt;

    // Result register
    logic signed [NUM_BITS-1:0] r_res_num;
    logic [DEN_BITS-1:0]        r_res_den;
    logic [STATUS_BITS-1:0]     r_status;

    // Shared multiplier operand selection
    logic signed [W-1:0]   mul_a, mul_b;
    logic signed [DW-1:0]  mul_p;

    always_comb begin
        mul_a = r_an;
        mul_b = $signed({1'b0, r_bd});
        unique case (i_cmd)
            DP_MUL0: begin
                mul_a = r_an;
                mul_b = (r_op == OP_MUL) ? r_bn : $signed({1'b0, r_bd});
            end
            DP_MUL1: begin
                mul_a = r_bn;
                mul_b = $signed({1'b0, r_ad});
            end
            DP_MUL2: begin
                mul_a = $signed({1'b0, r_ad});
                mul_b = (r_op == OP_DIV) ? r_bn : $signed({1'b0, r_bd});
            end
            default: begin
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Magnitudes of numerator and denominator
    logic          num_neg, den_neg;
    logic [DW-1:0] num_mag, den_mag;
    logic signed [NW-1:0] num_neg_v;
    logic signed [DW-1:0] den_neg_v;

    assign num_neg   = r_num[NW-1];
    assign den_neg   = r_prod[DW-1];
    assign num_neg_v = -r_num;
    assign den_neg_v = -r_prod;
    assign num_mag   = num_neg ? num_neg_v[DW-1:0] : r_num[DW-1:0];
    assign den_mag   = den_neg ? den_neg_v : r_prod;

    // Binary gcd step
    logic          u_ge_v;
    logic [DW-1:0] u_minus_v, v_minus_u;

    assign u_ge_v    = r_u >= r_v;
    assign u_minus_v = r_u - r_v;
    assign v_minus_u = r_v - r_u;

    // Restoring divider step
    logic [DW:0] div_trial, div_diff;

    assign div_trial = {r_rem, r_quo[DW-1]};
    assign div_diff  = div_trial - {1'b0, r_v};

    // Range check and sign of the reduced result
    logic          den_over, num_over;
    logic [DW-1:0] nq_signed;
    logic signed [W-1:0] res_w;

    assign den_over  = |r_quo[DW-1:W-1];
    assign num_over  = r_neg ? (r_nq > HALF) : (r_nq >= HALF);
    assign nq_signed = r_neg ? (DW'(0) - r_nq) : r_nq;
    assign res_w     = $signed(nq_signed[W-1:0]);

    // Status toward the controller
    assign o_sts.dz       = (r_ad == '0) || (r_bd == '0) || ((r_op == OP_DIV) && (r_bn == '0));
    assign o_sts.gcd_done = (r_u == '0);
    assign o_sts.div_done = (r_cnt == CW'(DW));

    // Execute commands
    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            DP_LOAD: begin
                r_op <= i_op;
                r_an <= i_a_num[W-1:0];
                r_bn <= i_b_num[W-1:0];
                r_ad <= i_a_den[W-2:0];
                r_bd <= i_b_den[W-2:0];
            end
            DP_MUL0: begin
                r_prod <= mul_p;
            end
            DP_MUL1: begin
                r_num  <= NW'(r_prod);
                r_prod <= mul_p;
            end
            DP_MUL2: begin
                if (r_op == OP_ADD) begin
                    r_num <= r_num + NW'(r_prod);
                end else if (r_op == OP_SUB) begin
                    r_num <= r_num - NW'(r_prod);
                end
                r_prod <= mul_p;
            end
            DP_MAG: begin
                r_nmag <= num_mag;
                r_dmag <= den_mag;
                r_u    <= num_mag;
                r_v    <= den_mag;
                r_k    <= '0;
                r_neg  <= (num_neg != den_neg) && (r_num != '0);
            end
            DP_GCD_STEP: begin
                if (!r_u[0] && !r_v[0]) begin
                    r_u <= r_u >> 1;
                    r_v <= r_v >> 1;
                    r_k <= r_k + 1'b1;
                end else if (!r_u[0]) begin
                    r_u <= r_u >> 1;
                end else if (!r_v[0]) begin
                    r_v <= r_v >> 1;
                end else if (u_ge_v) begin
                    r_u <= u_minus_v >> 1;
                end else begin
                    r_v <= v_minus_u >> 1;
                end
            end
            DP_DIVN_INIT: begin
                r_rem <= '0;
                r_quo <= r_nmag >> r_k;
                r_cnt <= '0;
            end
            DP_DIVD_INIT: begin
                r_nq  <= r_quo;
                r_rem <= '0;
                r_quo <= r_dmag >> r_k;
                r_cnt <= '0;
            end
            DP_DIV_STEP: begin
                if (!div_diff[DW]) begin
                    r_rem <= div_diff[DW-1:0];
                    r_quo <= {r_quo[DW-2:0], 1'b1};
                end else begin
                    r_rem <= div_trial[DW-1:0];
                    r_quo <= {r_quo[DW-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
            end
            DP_OUT: begin
                if (den_over || num_over) begin
                    r_res_num <= '0;
                    r_res_den <= '0;
                    r_status  <= ST_OVFL;
                end else begin
                    r_res_num <= NUM_BITS'(res_w);
                    r_res_den <= DEN_BITS'(r_quo[W-2:0]);
                    r_status  <= ST_OK;
                end
            end
            DP_OUT_DZ: begin
                r_res_num <= '0;
                r_res_den <= '0;
                r_status  <= ST_DZ;
            end
            default: begin
            end
        endcase
    end

    assign o_res_num = r_res_num;
    assign o_res_den = r_res_den;
    assign o_status  = r_status;

endmodule

// File: rtl/rau_ctrl.sv
// ----------------------------------------------------------------------------
// rau_ctrl: sequencer of the rational arithmetic unit
// Steps the datapath through products, gcd and two divisions per transaction.
// ----------------------------------------------------------------------------
module rau_ctrl import rau_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_MAG,
        S_GCD,
        S_DIVN,
        S_DIVD,
        S_FIN
    } t_state;

    t_state r_state;
    logic   r_dz;
    logic   r_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Decode the datapath command for this state
    always_comb begin
        o_cmd = DP_NONE;
        unique case (r_state)
            S_IDLE: o_cmd = i_in_valid ? DP_LOAD : DP_NONE;
            S_MUL0: o_cmd = i_sts.dz ? DP_NONE : DP_MUL0;
            S_MUL1: o_cmd = DP_MUL1;
            S_MUL2: o_cmd = DP_MUL2;
            S_MAG:  o_cmd = DP_MAG;
            S_GCD:  o_cmd = i_sts.gcd_done ? DP_DIVN_INIT : DP_GCD_STEP;
            S_DIVN: o_cmd = i_sts.div_done ? DP_DIVD_INIT : DP_DIV_STEP;
            S_DIVD: o_cmd = i_sts.div_done ? DP_NONE : DP_DIV_STEP;
            S_FIN:  o_cmd = out_free ? (r_dz ? DP_OUT_DZ : DP_OUT) : DP_NONE;
            default: o_cmd = DP_NONE;
        endcase
    end

    // Advance state and hold the result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dz        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_FIN) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_MUL0;
                    end
                end
                S_MUL0: begin
                    if (i_sts.dz) begin
                        r_dz    <= 1'b1;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: r_state <= S_MUL2;
                S_MUL2: r_state <= S_MAG;
                S_MAG:  r_state <= S_GCD;
                S_GCD: begin
                    if (i_sts.gcd_done) begin
                        r_state <= S_DIVN;
                    end
                end
                S_DIVN: begin
                    if (i_sts.div_done) begin
                        r_state <= S_DIVD;
                    end
                end
                S_DIVD: begin
                    if (i_sts.div_done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_dz    <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: exact add, subtract, multiply, divide of rationals
// Cross products, binary gcd and reduction to lowest terms with status.
// ----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+----------------------------------------
//  input    | i_in_valid / o_in_ready  | i_op, i_a_num, i_a_den, i_b_num, i_b_den
//  result   | o_out_valid / i_out_ready| o_res_num, o_res_den, o_status
//
//  One transaction at a time: load, the cross products on the shared
//  multiplier, the magnitudes, a binary gcd, then two restoring divisions.
//  A zero denominator or zero divisor goes straight to the result. The
//  result register lets the next transaction start while a result waits;
//  a stalled result only holds the final state. Reset clears the sequencer
//  and the result valid flag.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit import rau_pkg::*; #(
    parameter int WORD_W = WORD_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [OP_BITS-1:0]          i_op,
    input  logic signed [NUM_BITS-1:0]  i_a_num,
    input  logic [DEN_BITS-1:0]         i_a_den,
    input  logic signed [NUM_BITS-1:0]  i_b_num,
    input  logic [DEN_BITS-1:0]         i_b_den,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [NUM_BITS-1:0]  o_res_num,
    output logic [DEN_BITS-1:0]         o_res_den,
    output logic [STATUS_BITS-1:0]      o_status
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    rau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    rau_datapath #(
        .W (WORD_W)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .i_op      (i_op),
        .i_a_num   (i_a_num),
        .i_a_den   (i_a_den),
        .i_b_num   (i_b_num),
        .i_b_den   (i_b_den),
        .o_res_num (o_res_num),
        .o_res_den (o_res_den),
        .o_status  (o_status)
    );

endmodule

// File: test/rau_checker.sv
// ----------------------------------------------------------------------------
// rau_checker: result predictor and scoreboard for the rational arithmetic unit
// Watches both channels, computes the reduced rational for each accepted
// transaction and compares every returned result field by field.
// ----------------------------------------------------------------------------
module rau_checker import rau_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [OP_BITS-1:0]          i_op,
    input  logic signed [NUM_BITS-1:0]  i_a_num,
    input  logic [DEN_BITS-1:0]         i_a_den,
    input  logic signed [NUM_BITS-1:0]  i_b_num,
    input  logic [DEN_BITS-1:0]         i_b_den,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic signed [NUM_BITS-1:0]  i_res_num,
    input  logic [DEN_BITS-1:0]         i_res_den,
    input  logic [STATUS_BITS-1:0]      i_status,
    output int                          o_errors,
    output int                          o_pending
);

    typedef struct packed {
        logic signed [NUM_BITS-1:0] num;
        logic [DEN_BITS-1:0]        den;
        logic [STATUS_BITS-1:0]     status;
    } t_ratio;

    t_ratio pending_q[$];
    int     error_cnt;

    assign o_errors  = error_cnt;
    assign o_pending = pending_q.size();

    // Reduce the exact cross-product fraction to lowest terms
    function automatic t_ratio reduce_ratio(logic [OP_BITS-1:0] op,
                                            logic signed [NUM_BITS-1:0] an,
                                            logic [DEN_BITS-1:0] ad,
                                            logic signed [NUM_BITS-1:0] bn,
                                            logic [DEN_BITS-1:0] bd);
        t_ratio r;
        logic signed [63:0] num, den, san, sbn, sad, sbd;
        logic [63:0] nmag, dmag, x, y, t;
        logic neg;
        r = '0;
        r.status = ST_OK;
        san = an; sbn = bn;
        sad = {33'd0, ad}; sbd = {33'd0, bd};
        if (ad == 0 || bd == 0 || (op == OP_DIV && bn == 0)) begin
            r.status = ST_DZ;
            return r;
        end
        case (op)
            OP_ADD: begin num = san * sbd + sbn * sad; den = sad * sbd; end
            OP_SUB: begin num = san * sbd - sbn * sad; den = sad * sbd; end
            OP_MUL: begin num = san * sbn; den = sad * sbd; end
            default: begin num = san * sbd; den = sad * sbn; end
        endcase
        nmag = num[63] ? -num : num;
        dmag = den[63] ? -den : den;
        neg = (num[63] != den[63]) && nmag != 0;
        x = nmag; y = dmag;
        while (y != 0) begin
            t = x % y; x = y; y = t;
        end
        nmag = nmag / x;
        dmag = dmag / x;
        if (dmag > 64'h7FFF_FFFF || (neg ? nmag > 64'h8000_0000 : nmag > 64'h7FFF_FFFF)) begin
            r.status = ST_OVFL;
            return r;
        end
        r.num = neg ? -nmag[31:0] : nmag[31:0];
        r.den = dmag[30:0];
        return r;
    endfunction

    // Predict on input transactions, compare on result transactions
    always @(posedge i_clk) begin
        t_ratio exp_r;
        if (!i_rst_n) begin
            error_cnt <= 0;
        end else begin
            if (i_in_valid && i_in_ready)
                pending_q.push_back(reduce_ratio(i_op, i_a_num, i_a_den, i_b_num, i_b_den));
            if (i_out_valid && i_out_ready) begin
                if (pending_q.size() == 0) begin
                    $error("unexpected result transaction");
                    error_cnt <= error_cnt + 1;
                end else begin
                    exp_r = pending_q.pop_front();
                    if (exp_r.num !== i_res_num || exp_r.den !== i_res_den ||
                        exp_r.status !== i_status) begin
                        if (exp_r.num !== i_res_num)
                            $error("res_num expected %0d actual %0d", exp_r.num, i_res_num);
                        if (exp_r.den !== i_res_den)
                            $error("res_den expected %0d actual %0d", exp_r.den, i_res_den);
                        if (exp_r.status !== i_status)
                            $error("status expected %0d actual %0d", exp_r.status, i_status);
                        error_cnt <= error_cnt + 1;
                    end
                end
            end
        end
    end

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: regression for the rational arithmetic unit
// Directed corner operands, then random rationals with random gaps and
// stalls on both channels; the checker scores every result.
// ----------------------------------------------------------------------------
module testbench;
    import rau_pkg::*;

    localparam int N_RANDOM   = 1330;
    localparam int IDLE_LIMIT = 20000;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [OP_BITS-1:0]         op = OP_ADD;
    logic signed [NUM_BITS-1:0] a_num = '0;
    logic [DEN_BITS-1:0]        a_den = '0;
    logic signed [NUM_BITS-1:0] b_num = '0;
    logic [DEN_BITS-1:0]        b_den = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [NUM_BITS-1:0] res_num;
    logic [DEN_BITS-1:0]        res_den;
    logic [STATUS_BITS-1:0]     status;
    int                         errors, pending;
    bit                         hold_off = 1'b0;
    int                         idle_cycles = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    rational_arithmetic_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_op(op), .i_a_num(a_num), .i_a_den(a_den), .i_b_num(b_num), .i_b_den(b_den),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_res_num(res_num), .o_res_den(res_den), .o_status(status)
    );

    rau_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_op(op), .i_a_num(a_num), .i_a_den(a_den), .i_b_num(b_num), .i_b_den(b_den),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_res_num(res_num), .i_res_den(res_den), .i_status(status),
        .o_errors(errors), .o_pending(pending)
    );

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return 0;
        if (roll < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 400);
    endfunction

    // Pick an operand value: corners, small values or full range
    function automatic logic [31:0] pick_num();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2, 3: return $urandom_range(0, 40) - 20;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] pick_den();
        case ($urandom_range(0, 6))
            0: return 31'h7FFF_FFFF;
            1: return (($urandom_range(0, 19) == 0) ? 31'd0 : 31'd1);
            2, 3: return 31'($urandom_range(1, 30));
            default: return 31'($urandom);
        endcase
    endfunction

    // Offer one transaction and hold it until accepted
    task automatic send_item(logic [OP_BITS-1:0] o, logic [31:0] an, logic [30:0] ad,
                             logic [31:0] bn, logic [30:0] bd);
        op <= o; a_num <= an; a_den <= ad; b_num <= bn; b_den <= bd;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (!in_ready);
        @(negedge i_clk);
    endtask

    task automatic send_gap();
        int n;
        n = gap_len();
        if (n > 0) begin
            in_valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                out_ready <= 1'b0;
                repeat (2000) @(negedge i_clk);
                hold_off = 1'b0;
            end
            n = gap_len();
            out_ready <= (n == 0);
            if (n > 0) repeat (n - 1) @(negedge i_clk);
        end
    end

    // Watchdog on accepted transactions
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("rational_arithmetic_unit regression: fail");
            $finish;
        end
    end

    initial begin
        logic [OP_BITS-1:0] ops[4];
        ops = '{OP_ADD, OP_SUB, OP_MUL, OP_DIV};
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: every operation, zero denominators, zero divisor,
        // zero result, extremes and overflow
        foreach (ops[k]) send_item(ops[k], 32'd3, 31'd4, -32'sd5, 31'd6);
        send_item(OP_ADD, 32'd1, 31'd0, 32'd1, 31'd1);
        send_item(OP_MUL, 32'd1, 31'd1, 32'd1, 31'd0);
        send_item(OP_DIV, 32'd7, 31'd3, 32'd0, 31'd5);
        send_item(OP_SUB, 32'd5, 31'd7, 32'd5, 31'd7);
        send_item(OP_MUL, 32'd0, 31'h7FFF_FFFF, 32'h8000_0000, 31'd9);
        send_item(OP_MUL, 32'h8000_0000, 31'd1, 32'd1, 31'd1);
        send_item(OP_MUL, 32'h8000_0000, 31'd1, 32'hFFFF_FFFF, 31'd1);
        send_item(OP_DIV, 32'h8000_0000, 31'd1, 32'hFFFF_FFFF, 31'd1);
        send_item(OP_ADD, 32'h7FFF_FFFF, 31'd1, 32'h7FFF_FFFF, 31'd1);
        send_item(OP_SUB, 32'h8000_0000, 31'd1, 32'd1, 31'd1);
        send_item(OP_MUL, 32'd1, 31'h7FFF_FFFF, 32'd1, 31'h7FFF_FFFF);
        send_item(OP_DIV, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF);
        send_item(OP_ADD, 32'hFFFF_FFFF, 31'h5555_5555, 32'h0, 31'h2AAA_AAAA);
        send_item(OP_DIV, 32'd6, 31'd1, 32'hFFFF_FFFD, 31'd1);

        // Sender pause until every result has returned
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);

        // Long receiver hold-off while the sender keeps offering
        hold_off = 1'b1;
        for (int i = 0; i < 6; i++)
            send_item(ops[$urandom_range(0, 3)], pick_num(), pick_den(), pick_num(), pick_den());

        for (int i = 0; i < N_RANDOM; i++) begin
            send_gap();
            send_item(ops[$urandom_range(0, 3)], pick_num(), pick_den(), pick_num(), pick_den());
        end
        in_valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        if (errors == 0 && pending == 0)
            $display("rational_arithmetic_unit regression: pass");
        else
            $display("rational_arithmetic_unit regression: fail");
        $finish;
    end

endmodule
